@@ rtl/core/scpc_pkg.sv @@
// shared types and constants of the segment polygon clip unit
`timescale 1ns / 1ps
package scpc_pkg;

  // operations queued between front and back
  typedef enum logic [1:0] {
    OP_START,
    OP_EDGE,
    OP_EMIT
  } scpc_op_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_MUL,
    BS_CHECK,
    BS_PREP,
    BS_DIV,
    BS_ROUND,
    BS_UPD,
    BS_ALONG,
    BS_OUT
  } scpc_back_state_t;

  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam logic REG_PARALLEL_THRESHOLD = 1'b0;
  localparam logic [CFG_DATA_BITS-1:0] PARALLEL_THRESHOLD_RESET = 32'd1;
  localparam int unsigned OP_KIND_BITS = 2;

endpackage

@@ rtl/core/segment_convex_polygon_clip_unit.sv @@
// top level of the segment against convex polygon clip unit
`timescale 1ns / 1ps
// Clips one segment against a counter-clockwise convex polygon (Cyrus-Beck).
// The transaction that carries the first vertex (in_tuser high) also carries the
// segment; each later vertex closes one edge, and the last one (in_tlast) closes
// the polygon and gives one result: out_tuser is the hit flag, out_tdata holds
// the clipped start and end, all zero on a miss. The front accepts a vertex and
// queues up to three operations (start or edge, closing edge, emit) in a
// four-entry queue; the back runs each edge through one shared multiplier
// and a restoring divider that yields one quotient bit a cycle; the divider
// sets the sustained rate. t is a signed Q2.T_FRAC_BITS value rounded to
// nearest. Register 0 (byte address 0) is parallel_threshold, reset 1.
module segment_convex_polygon_clip_unit #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, vertex_x, vertex_y, zero fill
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // first_vertex
  input  logic in_tuser,
  input  logic in_tlast,
  output logic out_tvalid,
  input  logic out_tready,
  // clip_start_x, clip_start_y, clip_end_x, clip_end_y, zero fill
  output logic [((4*COORD_BITS+7)/8)*8-1:0] out_tdata,
  // hit
  output logic out_tuser,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [scpc_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [scpc_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [scpc_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic cfg_pready
);
  localparam int unsigned C = COORD_BITS;
  localparam int unsigned IN_W = ((6 * C + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((4 * C + 7) / 8) * 8;
  localparam int unsigned OP_W = 4 * C + scpc_pkg::OP_KIND_BITS;

  logic [scpc_pkg::CFG_DATA_BITS-1:0] threshold_r;
  logic push, full, pop, empty;
  logic [OP_W-1:0] push_data, pop_data;
  logic [4*C-1:0] out_coords;
  logic reg_sel;

  // configuration: register index sits at paddr bit 2
  assign cfg_pready = 1'b1;
  assign reg_sel = (cfg_paddr[2] == scpc_pkg::REG_PARALLEL_THRESHOLD);
  assign cfg_prdata = reg_sel ? threshold_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= scpc_pkg::PARALLEL_THRESHOLD_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      threshold_r <= cfg_pwdata;
    end
  end

  // front end: vertex bookkeeping
  scpc_front #(.COORD_BITS(C)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_fields_i(in_tdata[6*C-1:0]),
    .in_first_i (in_tuser),
    .in_last_i  (in_tlast),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  // decouples the vertex stream from the arithmetic
  scpc_fifo #(.DATA_W(OP_W), .DEPTH_LOG2(2)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  // back end: per-edge arithmetic and result
  scpc_back #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .threshold_i (threshold_r),
    .empty_i     (empty),
    .op_data_i   (pop_data),
    .pop_o       (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_hit_o   (out_tuser),
    .out_coords_o(out_coords)
  );

  assign out_tdata = OUT_W'(out_coords);
endmodule

@@ rtl/core/scpc_fifo.sv @@
// small operation queue between front and back
`timescale 1ns / 1ps
module scpc_fifo #(
  parameter int unsigned DATA_W = 98,
  parameter int unsigned DEPTH_LOG2 = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              empty_o
);
  localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DEPTH_LOG2:0] wr_ptr_r, rd_ptr_r;

  assign empty_o = (wr_ptr_r == rd_ptr_r);
  assign full_o  = (wr_ptr_r[DEPTH_LOG2-1:0] == rd_ptr_r[DEPTH_LOG2-1:0]) &&
                   (wr_ptr_r[DEPTH_LOG2] != rd_ptr_r[DEPTH_LOG2]);
  assign pop_data_o = mem_r[rd_ptr_r[DEPTH_LOG2-1:0]];

  always_ff @(posedge clk) begin
    if (push_i && !full_o) begin
      mem_r[wr_ptr_r[DEPTH_LOG2-1:0]] <= push_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push_i && !full_o) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_i && !empty_o) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end
endmodule

@@ rtl/core/scpc_front.sv @@
// front end: takes vertices, tracks first and previous vertex, queues operations
`timescale 1ns / 1ps
module scpc_front #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [6*COORD_BITS-1:0] in_fields_i,
  input  logic                  in_first_i,
  input  logic                  in_last_i,
  output logic                  push_o,
  output logic [4*COORD_BITS+scpc_pkg::OP_KIND_BITS-1:0] push_data_o,
  input  logic                  full_i
);
  localparam int unsigned C = COORD_BITS;

  logic [C-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [4*C-1:0] seg_r;
  logic [C-1:0] vx_r, vy_r, px_r, py_r, fx_r, fy_r;
  logic is_first_r;
  logic [2:0] pend_r;
  logic accept;
  logic [C-1:0] vx, vy;
  scpc_pkg::scpc_op_t kind;
  logic [4*C-1:0] data;

  assign vx = in_fields_i[5*C-1:4*C];
  assign vy = in_fields_i[6*C-1:5*C];
  assign in_tready = (pend_r == 3'b000);
  assign accept = in_tvalid && in_tready;
  assign push_o = (pend_r != 3'b000);
  assign push_data_o = {kind, data};

  always_comb begin
    kind = scpc_pkg::OP_EMIT;
    data = '0;
    if (pend_r[0]) begin
      if (is_first_r) begin
        kind = scpc_pkg::OP_START;
        data = seg_r;
      end else begin
        kind = scpc_pkg::OP_EDGE;
        data = {vy_r, vx_r, py_r, px_r};
      end
    end else if (pend_r[1]) begin
      kind = scpc_pkg::OP_EDGE;
      data = {fy_r, fx_r, vy_r, vx_r};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seg_r      <= in_fields_i[4*C-1:0];
      vx_r       <= vx;
      vy_r       <= vy;
      px_r       <= prev_x_r;
      py_r       <= prev_y_r;
      fx_r       <= in_first_i ? vx : first_x_r;
      fy_r       <= in_first_i ? vy : first_y_r;
      is_first_r <= in_first_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      pend_r    <= 3'b000;
    end else if (accept) begin
      prev_x_r <= vx;
      prev_y_r <= vy;
      if (in_first_i) begin
        first_x_r <= vx;
        first_y_r <= vy;
      end
      pend_r <= {in_last_i, in_last_i, 1'b1};
    end else if (push_o && !full_i) begin
      // retire lowest pending operation
      if (pend_r[0]) pend_r[0] <= 1'b0;
      else if (pend_r[1]) pend_r[1] <= 1'b0;
      else pend_r[2] <= 1'b0;
    end
  end
endmodule

@@ rtl/core/scpc_back.sv @@
// back end: edge products, shared divider, interval update and endpoint output
`timescale 1ns / 1ps
module scpc_back #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [scpc_pkg::CFG_DATA_BITS-1:0] threshold_i,
  input  logic empty_i,
  input  logic [4*COORD_BITS+scpc_pkg::OP_KIND_BITS-1:0] op_data_i,
  output logic pop_o,
  output logic out_tvalid,
  input  logic out_tready,
  output logic out_hit_o,
  output logic [4*COORD_BITS-1:0] out_coords_o
);
  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned F  = T_FRAC_BITS;
  localparam int unsigned CD = C + 1;
  localparam int unsigned W  = 2 * C + 3;
  localparam int unsigned RW = W + 1;
  localparam int unsigned QW = F + 2;
  localparam int unsigned TW = F + 3;
  localparam int unsigned PW = CD + TW;
  localparam int unsigned XW = (W > scpc_pkg::CFG_DATA_BITS) ? W : scpc_pkg::CFG_DATA_BITS;
  localparam int unsigned NW = $clog2(F + 1);
  localparam logic signed [TW-1:0] T_ONE = TW'(1) << F;
  localparam logic [QW-1:0] Q_TWO = QW'(1) << (F + 1);
  localparam logic signed [PW-1:0] HALF = PW'(1) << (F - 1);

  scpc_pkg::scpc_back_state_t state_r, state_nxt;

  logic [C-1:0] ax_r, ay_r;
  logic signed [CD-1:0] cx_r, cy_r, nx_r, ny_r, dx_r, dy_r;
  logic signed [W-1:0] den_r, num_r;
  logic [W-1:0] dmag_r, nmag_r;
  logic dpos_r, tneg_r, rej_r, hit_r;
  logic [QW-1:0] q_r;
  logic [RW-1:0] r_r;
  logic [NW-1:0] cnt_r;
  logic signed [TW-1:0] t_r, tin_r, tout_r;
  logic [2:0] k_r;
  logic signed [PW-1:0] prod_r;
  logic [C-1:0] res_r [4];

  scpc_pkg::scpc_op_t op_kind;
  logic [C-1:0] p0x, p0y, p1x, p1y;
  logic signed [CD-1:0] ma, mb;
  logic signed [2*CD-1:0] mprod;
  logic signed [W-1:0] mprod_w;
  logic [W-1:0] den_mag, num_mag;
  logic parallel;
  logic [RW-1:0] d_ext, rem;
  logic ge;
  logic [QW-1:0] tmag;
  logic signed [TW-1:0] tmag_s;
  logic signed [CD-1:0] c_sel;
  logic signed [TW-1:0] t_sel;
  logic signed [PW-1:0] aprod, shifted;
  logic [C-1:0] a_sel;
  logic signed [PW-1:0] coord;
  logic [1:0] ridx;
  logic out_free;

  assign op_kind = scpc_pkg::scpc_op_t'(op_data_i[4*C+scpc_pkg::OP_KIND_BITS-1:4*C]);
  assign p0x = op_data_i[C-1:0];
  assign p0y = op_data_i[2*C-1:C];
  assign p1x = op_data_i[3*C-1:2*C];
  assign p1y = op_data_i[4*C-1:3*C];
  assign pop_o = (state_r == scpc_pkg::BS_IDLE) && !empty_i;
  assign out_free = !out_tvalid || out_tready;

  // shared edge multiplier
  always_comb begin
    case (k_r[1:0])
      2'd0: begin ma = nx_r; mb = cx_r; end
      2'd1: begin ma = ny_r; mb = cy_r; end
      2'd2: begin ma = nx_r; mb = dx_r; end
      default: begin ma = ny_r; mb = dy_r; end
    endcase
    mprod   = ma * mb;
    mprod_w = W'(mprod);
  end

  assign den_mag  = den_r[W-1] ? W'(-den_r) : den_r;
  assign num_mag  = num_r[W-1] ? W'(-num_r) : num_r;
  assign parallel = (den_r == '0) || (XW'(den_mag) < XW'(threshold_i));

  assign d_ext = {1'b0, dmag_r};
  assign ge    = (r_r >= d_ext);
  assign rem   = ge ? (r_r - d_ext) : r_r;
  assign tmag  = q_r + QW'(ge);
  assign tmag_s = $signed({1'b0, tmag});

  // endpoint multiplier
  assign c_sel   = k_r[0] ? cy_r : cx_r;
  assign t_sel   = k_r[1] ? tout_r : tin_r;
  assign aprod   = PW'(c_sel * t_sel);
  assign ridx    = 2'(k_r - 3'd1);
  assign a_sel   = ridx[0] ? ay_r : ax_r;
  assign shifted = (prod_r + HALF) >>> F;
  assign coord   = PW'($signed(a_sel)) + shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= scpc_pkg::BS_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scpc_pkg::BS_IDLE: begin
        if (!empty_i) begin
          unique case (op_kind)
            scpc_pkg::OP_START: state_nxt = scpc_pkg::BS_IDLE;
            scpc_pkg::OP_EDGE:  state_nxt = rej_r ? scpc_pkg::BS_IDLE : scpc_pkg::BS_MUL;
            scpc_pkg::OP_EMIT:  state_nxt = rej_r ? scpc_pkg::BS_OUT : scpc_pkg::BS_ALONG;
            default:            state_nxt = scpc_pkg::BS_IDLE;
          endcase
        end
      end
      scpc_pkg::BS_MUL:   if (k_r == 3'd3) state_nxt = scpc_pkg::BS_CHECK;
      scpc_pkg::BS_CHECK: state_nxt = parallel ? scpc_pkg::BS_IDLE : scpc_pkg::BS_PREP;
      scpc_pkg::BS_PREP: begin
        if ({1'b0, nmag_r} >= {dmag_r, 1'b0}) state_nxt = scpc_pkg::BS_ROUND;
        else state_nxt = scpc_pkg::BS_DIV;
      end
      scpc_pkg::BS_DIV:   if (cnt_r == NW'(F)) state_nxt = scpc_pkg::BS_ROUND;
      scpc_pkg::BS_ROUND: state_nxt = scpc_pkg::BS_UPD;
      scpc_pkg::BS_UPD:   state_nxt = scpc_pkg::BS_IDLE;
      scpc_pkg::BS_ALONG: if (k_r == 3'd4) state_nxt = scpc_pkg::BS_OUT;
      scpc_pkg::BS_OUT:   if (out_free) state_nxt = scpc_pkg::BS_IDLE;
      default:            state_nxt = scpc_pkg::BS_IDLE;
    endcase
  end

  // interval and segment state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r   <= '0;
      ay_r   <= '0;
      cx_r   <= '0;
      cy_r   <= '0;
      tin_r  <= '0;
      tout_r <= T_ONE;
      rej_r  <= 1'b0;
    end else begin
      if (state_r == scpc_pkg::BS_IDLE && !empty_i && op_kind == scpc_pkg::OP_START) begin
        ax_r   <= p0x;
        ay_r   <= p0y;
        cx_r   <= CD'($signed(p1x)) - CD'($signed(p0x));
        cy_r   <= CD'($signed(p1y)) - CD'($signed(p0y));
        tin_r  <= '0;
        tout_r <= T_ONE;
        rej_r  <= 1'b0;
      end
      if (state_r == scpc_pkg::BS_CHECK && parallel && num_r[W-1]) rej_r <= 1'b1;
      if (state_r == scpc_pkg::BS_UPD) begin
        if (dpos_r) begin
          if (t_r < tout_r) begin
            if (t_r < tin_r) rej_r <= 1'b1;
            else tout_r <= t_r;
          end
        end else if (t_r > tin_r) begin
          if (t_r > tout_r) rej_r <= 1'b1;
          else tin_r <= t_r;
        end
      end
    end
  end

  // edge datapath
  always_ff @(posedge clk) begin
    case (state_r)
      scpc_pkg::BS_IDLE: begin
        k_r  <= '0;
        nx_r <= CD'($signed(p1y)) - CD'($signed(p0y));
        ny_r <= CD'($signed(p0x)) - CD'($signed(p1x));
        dx_r <= CD'($signed(p0x)) - CD'($signed(ax_r));
        dy_r <= CD'($signed(p0y)) - CD'($signed(ay_r));
        if (!empty_i && op_kind == scpc_pkg::OP_EMIT) begin
          hit_r <= !rej_r;
          if (rej_r) begin
            for (int i = 0; i < 4; i++) res_r[i] <= '0;
          end
        end
      end
      scpc_pkg::BS_MUL: begin
        k_r <= k_r + 3'd1;
        case (k_r[1:0])
          2'd0:    den_r <= mprod_w;
          2'd1:    den_r <= den_r + mprod_w;
          2'd2:    num_r <= mprod_w;
          default: num_r <= num_r + mprod_w;
        endcase
      end
      scpc_pkg::BS_CHECK: begin
        dmag_r <= den_mag;
        nmag_r <= num_mag;
        dpos_r <= !den_r[W-1];
        tneg_r <= num_r[W-1] ^ den_r[W-1];
      end
      scpc_pkg::BS_PREP: begin
        cnt_r <= '0;
        if ({1'b0, nmag_r} >= {dmag_r, 1'b0}) begin
          // quotient of two or more saturates
          q_r <= Q_TWO;
          r_r <= '0;
        end else begin
          q_r <= '0;
          r_r <= {1'b0, nmag_r};
        end
      end
      scpc_pkg::BS_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        q_r   <= {q_r[QW-2:0], ge};
        r_r   <= {rem[RW-2:0], 1'b0};
      end
      scpc_pkg::BS_ROUND: begin
        t_r <= tneg_r ? -tmag_s : tmag_s;
      end
      scpc_pkg::BS_ALONG: begin
        k_r    <= k_r + 3'd1;
        prod_r <= aprod;
        if (k_r != 3'd0) res_r[ridx] <= coord[C-1:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (state_r == scpc_pkg::BS_OUT && out_free) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == scpc_pkg::BS_OUT && out_free) begin
      out_hit_o    <= hit_r;
      out_coords_o <= {res_r[3], res_r[2], res_r[1], res_r[0]};
    end
  end
endmodule

@@ rtl/core/scpc_checker.sv @@
// port-level checks of the clip unit and their binding
`timescale 1ns / 1ps
module scpc_checker #(
  parameter int unsigned OUT_W = 96
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic out_tuser,
  input logic cfg_pready
);
  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a miss carries zero coordinates
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss with non-zero coordinates");

  // front is busy in the cycle after each accepted vertex
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("vertex accepted on consecutive cycles");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("configuration port stalled");
endmodule

bind segment_convex_polygon_clip_unit scpc_checker #(
  .OUT_W(((4*COORD_BITS+7)/8)*8)
) u_scpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .cfg_pready(cfg_pready)
);
